// File: sv/vvtp_pkg.sv
package vvtp_pkg;

  // Register indexes
  typedef enum logic [2:0] {
    REG_MODEL_YAW    = 3'd0,
    REG_MODEL_PITCH  = 3'd1,
    REG_CAMERA_YAW   = 3'd2,
    REG_CAMERA_PITCH = 3'd3,
    REG_CAMERA_X     = 3'd4,
    REG_CAMERA_Y     = 3'd5,
    REG_CAMERA_Z     = 3'd6,
    REG_VIEW_SETUP   = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned QuoW     = 50;

  localparam logic [63:0] RotReset  = 64'h4000_0000_0000_0000;
  localparam logic [47:0] ViewReset = 48'h0100_0140_00F0;

  // Combine two Q16.16 x Q2.30 products into a wrapped Q16.16 result.
  function automatic logic [31:0] rot_sum(input logic signed [63:0] p0,
                                          input logic signed [63:0] p1,
                                          input logic               sub);
    logic signed [63:0] s;
    begin
      s = sub ? (p0 - p1) : (p0 + p1);
      rot_sum = s[61:30];
    end
  endfunction

endpackage

// File: sv/vvtp_divider.sv
// Pipelined signed divider, truncating toward zero.
// One quotient bit per stage; the numerator magnitude is at most 50 bits.
module vvtp_divider
  import vvtp_pkg::*;
#(
  parameter int unsigned TagW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [QuoW:0]   num_i,
  input  logic signed [31:0]     den_i,
  input  logic [TagW-1:0]        tag_i,
  output logic                   valid_o,
  output logic signed [QuoW:0]   quo_o,
  output logic [TagW-1:0]        tag_o
);

  localparam int unsigned N = QuoW;

  typedef struct packed {
    logic [N-1:0] rem_quo;
    logic [N-1:0] part;
    logic [31:0]  den;
    logic         neg;
    logic [TagW-1:0] tag;
  } div_stage_t;

  div_stage_t st_q [N+1];
  logic       vld_q [N+1];

  // entry stage: magnitudes and sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (en_i) vld_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem_quo <= num_i[N] ? N'(-num_i) : num_i[N-1:0];
      st_q[0].part    <= '0;
      st_q[0].den     <= den_i[31] ? 32'(-den_i) : den_i;
      st_q[0].neg     <= num_i[N] ^ den_i[31];
      st_q[0].tag     <= tag_i;
    end
  end

  // restoring stages
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N:0]   trial;
    logic [N-1:0] shifted;
    logic         take;
    always_comb begin
      shifted = {st_q[k].part[N-2:0], st_q[k].rem_quo[N-1]};
      trial   = {1'b0, shifted} - {{(N-31){1'b0}}, st_q[k].den};
      take    = !trial[N];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (en_i) vld_q[k+1] <= vld_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1].part    <= take ? trial[N-1:0] : shifted;
        st_q[k+1].rem_quo <= {st_q[k].rem_quo[N-2:0], take};
        st_q[k+1].den     <= st_q[k].den;
        st_q[k+1].neg     <= st_q[k].neg;
        st_q[k+1].tag     <= st_q[k].tag;
      end
    end
  end

  assign valid_o = vld_q[N];
  assign quo_o   = st_q[N].neg ? -$signed({1'b0, st_q[N].rem_quo})
                               : $signed({1'b0, st_q[N].rem_quo});
  assign tag_o   = st_q[N].tag;

endmodule

// File: sv/vertex_view_transform_project.sv
// Vertex view transform and perspective projection. One vertex is accepted
// per cycle and results leave in order, one per cycle. The path is an input
// register, 2 rotations of 2 stages each (multiply, sum), one translation
// stage, 2 more such rotations and one projection numerator stage.
// A 51-stage bit-per-stage divider follows: an entry stage plus one stage per
// quotient bit. It dominates the latency. An output register ends the path.
// The whole pipe advances together; it stalls only when the output holds a
// result not taken.
// Write configuration only while no vertex is in flight.
module vertex_view_transform_project
  import vvtp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [31:0]         vertex_x_i,
  input  logic signed [31:0]         vertex_y_i,
  input  logic signed [31:0]         vertex_z_i,
  input  logic                       last_vertex_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         view_x_o,
  output logic signed [31:0]         view_y_o,
  output logic signed [31:0]         view_z_o,
  output logic signed [15:0]         screen_x_o,
  output logic signed [15:0]         screen_y_o,
  output logic                       depth_zero_o,
  output logic                       screen_saturated_o,
  output logic                       last_out_o
);

  // configuration registers
  logic [63:0] rot_q [4];
  logic [31:0] cam_q [3];
  logic [47:0] view_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) rot_q[i] <= RotReset;
      for (int i = 0; i < 3; i++) cam_q[i] <= '0;
      view_q <= ViewReset;
    end else if (cfg_we_i && !cfg_idx_i[3]) begin
      case (reg_idx_e'(cfg_idx_i[2:0]))
        REG_MODEL_YAW:    rot_q[0] <= cfg_data_i;
        REG_MODEL_PITCH:  rot_q[1] <= cfg_data_i;
        REG_CAMERA_YAW:   rot_q[2] <= cfg_data_i;
        REG_CAMERA_PITCH: rot_q[3] <= cfg_data_i;
        REG_CAMERA_X:     cam_q[0] <= cfg_data_i[31:0];
        REG_CAMERA_Y:     cam_q[1] <= cfg_data_i[31:0];
        REG_CAMERA_Z:     cam_q[2] <= cfg_data_i[31:0];
        REG_VIEW_SETUP:   view_q   <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // global pipeline enable
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } vtx_t;

  typedef struct packed {
    logic signed [63:0] ac;
    logic signed [63:0] bs;
    logic signed [63:0] bc;
    logic signed [63:0] as_;
    logic [31:0]        other;
    logic               last;
  } prod_t;

  // rotation planes: 0,2 act on (x,z); 1,3 on (y,z)
  vtx_t  vin_q [5];
  logic  vv_q [5];
  prod_t pr_q [4];
  logic  pv_q [4];
  vtx_t  tr_q;
  logic  tv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vin_q[0] <= '{x: vertex_x_i, y: vertex_y_i, z: vertex_z_i, last: last_vertex_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) vv_q[i] <= 1'b0;
      for (int i = 0; i < 4; i++) pv_q[i] <= 1'b0;
      tv_q <= 1'b0;
    end else if (en) begin
      vv_q[0] <= in_valid_i;
      pv_q[0] <= vv_q[0];
      vv_q[1] <= pv_q[0];
      pv_q[1] <= vv_q[1];
      vv_q[2] <= pv_q[1];
      tv_q    <= vv_q[2];
      pv_q[2] <= tv_q;
      vv_q[3] <= pv_q[2];
      pv_q[3] <= vv_q[3];
      vv_q[4] <= pv_q[3];
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_rot
    vtx_t               src;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] s;
    always_comb begin
      src = (r == 2) ? tr_q : vin_q[r];
      a   = (r % 2 == 0) ? src.x : src.y;
      b   = src.z;
      c   = rot_q[r][63:32];
      s   = rot_q[r][31:0];
    end
    // multiply stage
    always_ff @(posedge clk_i) begin
      if (en) begin
        pr_q[r].ac    <= 64'(a * c);
        pr_q[r].bs    <= 64'(b * s);
        pr_q[r].bc    <= 64'(b * c);
        pr_q[r].as_   <= 64'(a * s);
        pr_q[r].other <= (r % 2 == 0) ? src.y : src.x;
        pr_q[r].last  <= src.last;
      end
    end
    // sum and shift stage
    logic [31:0] na;
    logic [31:0] nb;
    assign na = rot_sum(pr_q[r].ac, pr_q[r].bs, 1'b1);
    assign nb = rot_sum(pr_q[r].bc, pr_q[r].as_, 1'b0);
    always_ff @(posedge clk_i) begin
      if (en) begin
        vin_q[r+1].z    <= nb;
        vin_q[r+1].last <= pr_q[r].last;
        if (r % 2 == 0) begin
          vin_q[r+1].x <= na;
          vin_q[r+1].y <= pr_q[r].other;
        end else begin
          vin_q[r+1].y <= na;
          vin_q[r+1].x <= pr_q[r].other;
        end
      end
    end
  end

  // camera translation
  always_ff @(posedge clk_i) begin
    if (en) begin
      tr_q.x    <= vin_q[2].x - cam_q[0];
      tr_q.y    <= vin_q[2].y - cam_q[1];
      tr_q.z    <= vin_q[2].z - cam_q[2];
      tr_q.last <= vin_q[2].last;
    end
  end

  // projection numerators c*z + v*fov
  logic signed [QuoW:0] numx_q, numy_q;
  vtx_t                 nv_q;
  logic                 nvld_q;
  logic signed [31:0]   zs;
  assign zs = vin_q[4].z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nvld_q <= 1'b0;
    else if (en) nvld_q <= vv_q[4];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_q <= (QuoW+1)'($signed({1'b0, view_q[31:16]}) * zs
              + $signed(vin_q[4].x) * $signed({1'b0, view_q[47:32]}));
      numy_q <= (QuoW+1)'($signed({1'b0, view_q[15:0]}) * zs
              + $signed(vin_q[4].y) * $signed({1'b0, view_q[47:32]}));
      nv_q   <= vin_q[4];
    end
  end

  // dividers; view vertex rides along as tag
  localparam int unsigned TagW = $bits(vtx_t);
  logic                 dvx, dvy;
  logic signed [QuoW:0] qx, qy;
  logic [TagW-1:0]      tagx, tagy;
  logic [31:0]          zden;
  assign zden = (nv_q.z == '0) ? 32'd1 : nv_q.z;

  vvtp_divider #(.TagW(TagW)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(nvld_q), .num_i(numx_q),
    .den_i(zden), .tag_i(nv_q), .valid_o(dvx), .quo_o(qx), .tag_o(tagx)
  );

  vvtp_divider #(.TagW(1)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(nvld_q), .num_i(numy_q),
    .den_i(zden), .tag_i(1'b0), .valid_o(dvy), .quo_o(qy), .tag_o(tagy[0])
  );
  assign tagy[TagW-1:1] = '0;

  // clamp and output register
  vtx_t        fv;
  logic        zz, satx, saty;
  logic [15:0] cx, cy;
  always_comb begin
    fv   = vtx_t'(tagx);
    zz   = (fv.z == '0);
    satx = (qx > 32767) || (qx < -32768);
    saty = (qy > 32767) || (qy < -32768);
    cx   = (qx > 32767) ? 16'h7FFF : (qx < -32768) ? 16'h8000 : qx[15:0];
    cy   = (qy > 32767) ? 16'h7FFF : (qy < -32768) ? 16'h8000 : qy[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= dvx && (dvy || !tagy[TagW-1]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      view_x_o           <= fv.x;
      view_y_o           <= fv.y;
      view_z_o           <= fv.z;
      screen_x_o         <= zz ? '0 : cx;
      screen_y_o         <= zz ? '0 : cy;
      depth_zero_o       <= zz;
      screen_saturated_o <= !zz && (satx || saty);
      last_out_o         <= fv.last;
    end
  end

endmodule

// File: sv/vvtp_checker.sv
module vvtp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        depth_zero_o,
  input logic        screen_saturated_o,
  input logic [15:0] screen_x_o,
  input logic [15:0] screen_y_o,
  input logic [31:0] view_z_o
);

  // a stalled output holds its result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(screen_x_o))
    else $error("result dropped while stalled");

  // input stalls only behind a stalled output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without backpressure");

  // zero depth flag matches depth and clears screen
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (depth_zero_o == (view_z_o == 32'd0)) &&
      (!depth_zero_o || (screen_x_o == 16'd0 && screen_y_o == 16'd0 && !screen_saturated_o)))
    else $error("zero depth result wrong");

endmodule

bind vertex_view_transform_project vvtp_checker u_vvtp_checker (.*);
